[design/wmf_pkg.sv]
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared widths, payload types and default sizes of the RGB median filter.
// ----------------------------------------------------------------------------
package wmf_pkg;

  localparam int PIX_W    = 8;
  localparam int CFG_W    = 12;
  localparam int CENTER_W = 11;

  localparam int WINDOW_DEF     = 3;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  // image width after reset
  localparam logic [CFG_W-1:0] WIDTH_RST = 12'd2048;

  // one pixel as kept in the line RAMs and the window, blue in the low byte
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  // per-pixel sideband that travels with the pixel down the pipe
  typedef struct packed {
    logic                produce;
    logic [CENTER_W-1:0] center_row;
    logic [CENTER_W-1:0] center_col;
  } meta_t;

endpackage

[design/wmf_pix_if.sv]
// ----------------------------------------------------------------------------
// wmf_pix_if
// Valid/ready channel that carries one input pixel per beat.
// ----------------------------------------------------------------------------
interface wmf_pix_if import wmf_pkg::*; ();

  logic             valid;
  logic             ready;
  logic             start_of_frame;
  logic [PIX_W-1:0] blue_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] red_in;

  modport source (output valid, start_of_frame, blue_in, green_in, red_in, input ready);
  modport sink   (input valid, start_of_frame, blue_in, green_in, red_in, output ready);

endinterface

[design/wmf_res_if.sv]
// ----------------------------------------------------------------------------
// wmf_res_if
// Valid/ready channel that carries one filtered pixel and its position per beat.
// ----------------------------------------------------------------------------
interface wmf_res_if import wmf_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [PIX_W-1:0]    blue_out;
  logic [PIX_W-1:0]    green_out;
  logic [PIX_W-1:0]    red_out;
  logic [CENTER_W-1:0] center_row;
  logic [CENTER_W-1:0] center_column;

  modport source (output valid, blue_out, green_out, red_out, center_row, center_column,
                  input ready);
  modport sink   (input valid, blue_out, green_out, red_out, center_row, center_column,
                  output ready);

endinterface

[design/wmf_ram.sv]
// ----------------------------------------------------------------------------
// wmf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wmf_ram import wmf_pkg::*; #(
  parameter int WIDTH = $bits(rgb_t),
  parameter int DEPTH = MAX_WIDTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/wmf_median.sv]
// ----------------------------------------------------------------------------
// wmf_median
// Median of one channel over the window, by rank counting in parallel.
// ----------------------------------------------------------------------------
module wmf_median import wmf_pkg::*; #(
  parameter int AREA = WINDOW_DEF * WINDOW_DEF
) (
  input  logic [PIX_W-1:0] vals [AREA],
  output logic [PIX_W-1:0] median
);

  localparam int MID = AREA / 2;

  logic [AREA-1:0] lt_m [AREA];
  logic [AREA-1:0] le_m [AREA];
  logic [AREA-1:0] hit;

  // entry i sits at rank MID when fewer than MID+1 values are below it
  // and more than MID values are at or below it
  always_comb begin
    for (int i = 0; i < AREA; i++) begin
      for (int j = 0; j < AREA; j++) begin
        lt_m[i][j] = vals[j] <  vals[i];
        le_m[i][j] = vals[j] <= vals[i];
      end
      hit[i] = ($countones(lt_m[i]) <= MID) && ($countones(le_m[i]) > MID);
    end
  end

  // all hits carry the same value, so OR them together
  always_comb begin
    median = '0;
    for (int i = 0; i < AREA; i++) begin
      median = median | ({PIX_W{hit[i]}} & vals[i]);
    end
  end

endmodule

[design/wmf_window.sv]
// ----------------------------------------------------------------------------
// wmf_window
// Line RAMs and the sliding square window. Reads the stored rows of a column,
// rotates them down one row and shifts the column into the window.
// ----------------------------------------------------------------------------
module wmf_window import wmf_pkg::*; #(
  parameter int WINDOW    = WINDOW_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int CW       = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [CW-1:0] in_col,
  input  rgb_t          in_pix,
  input  meta_t         in_meta,
  output logic          out_valid,
  input  logic          out_ready,
  output rgb_t          win [WINDOW][WINDOW],
  output meta_t         out_meta
);

  localparam int LINES = WINDOW - 1;

  // column stage: line RAM data is valid here
  logic          v2_r;
  logic [CW-1:0] col2_r;
  rgb_t          pix2_r;
  meta_t         meta2_r;
  logic          byp_r;
  rgb_t          byp_data_r [LINES];

  // window stage
  logic          v3_r;
  meta_t         meta3_r;
  rgb_t          win_r [WINDOW][WINDOW];

  logic en2;
  logic en3;
  logic wr_en;
  rgb_t rd_data [LINES];
  rgb_t line    [LINES];
  rgb_t wr_data [LINES];
  rgb_t column  [WINDOW];

  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign in_ready = en2;
  assign wr_en    = v2_r && en3;

  always_comb begin
    for (int k = 0; k < LINES; k++) begin
      line[k] = byp_r ? byp_data_r[k] : rd_data[k];
    end
    // row 0 gets the new pixel, each older row takes the one above it
    wr_data[0] = pix2_r;
    for (int k = 1; k < LINES; k++) begin
      wr_data[k] = line[k-1];
    end
    column[WINDOW-1] = pix2_r;
    for (int k = 1; k < WINDOW; k++) begin
      column[WINDOW-1-k] = line[k-1];
    end
  end

  for (genvar k = 0; k < LINES; k++) begin : g_line
    wmf_ram #(
      .WIDTH ($bits(rgb_t)),
      .DEPTH (MAX_WIDTH)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr_en),
      .wr_addr (col2_r),
      .wr_data (wr_data[k]),
      .rd_en   (en2),
      .rd_addr (in_col),
      .rd_data (rd_data[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r  <= 1'b0;
      byp_r <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      if (en2) begin
        v2_r  <= in_valid;
        // the RAM read misses a write to the same column at this edge
        byp_r <= in_valid && wr_en && (in_col == col2_r);
      end
      if (en3) begin
        v3_r <= v2_r && meta2_r.produce;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      col2_r  <= in_col;
      pix2_r  <= in_pix;
      meta2_r <= in_meta;
      for (int k = 0; k < LINES; k++) begin
        byp_data_r[k] <= wr_data[k];
      end
    end
    if (wr_en) begin
      meta3_r <= meta2_r;
      for (int k = 0; k < WINDOW; k++) begin
        for (int x = 0; x < WINDOW - 1; x++) begin
          win_r[k][x] <= win_r[k][x+1];
        end
        win_r[k][WINDOW-1] <= column[k];
      end
    end
  end

  assign out_valid = v3_r;
  assign out_meta  = meta3_r;
  assign win       = win_r;

  a_byp_has_item : assert property (@(posedge clk) disable iff (!rst_n)
    byp_r |-> v2_r)
    else $error("bypass set with no column in flight");

  a_v3_produces : assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && en3 && !meta2_r.produce) |=> !v3_r)
    else $error("border pixel reached the window output");

  a_win_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !out_ready) |=> v3_r && $stable(meta3_r))
    else $error("window result changed while stalled");

endmodule

[design/window_median_filter_rgb_unit.sv]
// ----------------------------------------------------------------------------
// window_median_filter_rgb_unit
// Square-window median filter over RGB pixels in raster order.
//
// in_pix carries one pixel per beat; start_of_frame marks row 0, column 0.
// out_res carries, for every pixel that is the center of a full window, the
// per-channel median and the center's row and column. Border pixels give no
// beat. cfg_wr_en / cfg_wr_data set the image width (0 counts as 1, values
// above MAX_WIDTH count as MAX_WIDTH); write it only while the block is idle.
//
// Throughput: one pixel per cycle while out_res takes results. A result passes
// the input register, the line RAM read, the window register and then the
// output register behind the median logic before it is on out_res.
// A stalled out_res holds the result and the pipe keeps filling its empty
// stages; in_pix.ready drops only once every stage holds a pixel.
// Reset clears the row and column counters and the pipe and sets the width
// to 2048; line RAM and window contents are not cleared and need no pass.
// ----------------------------------------------------------------------------
module window_median_filter_rgb_unit import wmf_pkg::*; #(
  parameter int WINDOW     = WINDOW_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  wmf_pix_if.sink          in_pix,
  wmf_res_if.source        out_res,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  localparam int HALF  = WINDOW / 2;
  localparam int AREA  = WINDOW * WINDOW;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = CW + 1;
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CMP_W = CFG_W + 1;
  localparam logic [WW-1:0] WIDTH_INIT =
    (int'(WIDTH_RST) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(WIDTH_RST);

  logic [WW-1:0] width_r;
  logic [WW-1:0] width_cfg;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_nxt;
  logic [RW-1:0] row_nxt;
  logic [CW-1:0] col_use;
  logic [RW-1:0] row_use;
  logic [WW-1:0] col_inc;
  logic          in_acc;

  logic          s1_v_r;
  logic [CW-1:0] s1_col_r;
  rgb_t          s1_pix_r;
  meta_t         s1_meta_r;
  meta_t         meta_in;

  logic          win_ready;
  logic          win_valid;
  rgb_t          win [WINDOW][WINDOW];
  meta_t         win_meta;

  logic [PIX_W-1:0] blue_vals  [AREA];
  logic [PIX_W-1:0] green_vals [AREA];
  logic [PIX_W-1:0] red_vals   [AREA];
  logic [PIX_W-1:0] blue_med;
  logic [PIX_W-1:0] green_med;
  logic [PIX_W-1:0] red_med;

  logic                out_v_r;
  logic                out_en;
  logic [PIX_W-1:0]    out_blue_r;
  logic [PIX_W-1:0]    out_green_r;
  logic [PIX_W-1:0]    out_red_r;
  logic [CENTER_W-1:0] out_row_r;
  logic [CENTER_W-1:0] out_col_r;

  // clamp the written width into 1..MAX_WIDTH
  always_comb begin
    if (cfg_wr_data == '0) begin
      width_cfg = WW'(1);
    end else if (CMP_W'(cfg_wr_data) > CMP_W'(MAX_WIDTH)) begin
      width_cfg = WW'(MAX_WIDTH);
    end else begin
      width_cfg = WW'(cfg_wr_data);
    end
  end

  assign in_pix.ready = !s1_v_r || win_ready;
  assign in_acc       = in_pix.valid && in_pix.ready;

  always_comb begin
    col_use = in_pix.start_of_frame ? '0 : col_r;
    row_use = in_pix.start_of_frame ? '0 : row_r;
    col_inc = {1'b0, col_use} + WW'(1);
    if (col_inc >= width_r) begin
      col_nxt = '0;
      row_nxt = (row_use < RW'(MAX_HEIGHT - 1)) ? row_use + RW'(1) : row_use;
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = row_use;
    end
    meta_in.produce    = (row_use >= RW'(WINDOW - 1)) && (col_use >= CW'(WINDOW - 1));
    meta_in.center_row = CENTER_W'(row_use - RW'(HALF));
    meta_in.center_col = CENTER_W'(col_use - CW'(HALF));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_INIT;
      col_r   <= '0;
      row_r   <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        width_r <= width_cfg;
      end
      if (in_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (in_pix.ready) begin
        s1_v_r <= in_pix.valid;
      end
      if (out_en) begin
        out_v_r <= win_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r  <= col_use;
      s1_pix_r  <= '{red: in_pix.red_in, green: in_pix.green_in, blue: in_pix.blue_in};
      s1_meta_r <= meta_in;
    end
  end

  wmf_window #(
    .WINDOW    (WINDOW),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_v_r),
    .in_ready  (win_ready),
    .in_col    (s1_col_r),
    .in_pix    (s1_pix_r),
    .in_meta   (s1_meta_r),
    .out_valid (win_valid),
    .out_ready (out_en),
    .win       (win),
    .out_meta  (win_meta)
  );

  always_comb begin
    for (int k = 0; k < WINDOW; k++) begin
      for (int x = 0; x < WINDOW; x++) begin
        blue_vals[k*WINDOW + x]  = win[k][x].blue;
        green_vals[k*WINDOW + x] = win[k][x].green;
        red_vals[k*WINDOW + x]   = win[k][x].red;
      end
    end
  end

  wmf_median #(.AREA(AREA)) u_med_blue  (.vals(blue_vals),  .median(blue_med));
  wmf_median #(.AREA(AREA)) u_med_green (.vals(green_vals), .median(green_med));
  wmf_median #(.AREA(AREA)) u_med_red   (.vals(red_vals),   .median(red_med));

  assign out_en = !out_v_r || out_res.ready;

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_blue_r  <= blue_med;
      out_green_r <= green_med;
      out_red_r   <= red_med;
      out_row_r   <= win_meta.center_row;
      out_col_r   <= win_meta.center_col;
    end
  end

  assign out_res.valid         = out_v_r;
  assign out_res.blue_out      = out_blue_r;
  assign out_res.green_out     = out_green_r;
  assign out_res.red_out       = out_red_r;
  assign out_res.center_row    = out_row_r;
  assign out_res.center_column = out_col_r;

  a_sof_restart : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_pix.start_of_frame) |=> (s1_col_r == '0) && !s1_meta_r.produce)
    else $error("start of frame did not restart the counters");

  a_produce_interior : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_meta_r.produce) |-> (s1_col_r >= CW'(WINDOW - 1)))
    else $error("result flagged for a border column");

  a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !win_ready) |=> s1_v_r && $stable(s1_col_r))
    else $error("input stage lost a pixel while stalled");

endmodule

[tb/wmf_median_checker.sv]
// ----------------------------------------------------------------------------
// wmf_median_checker
// Watches the pixel, result and width ports of the RGB median filter. Each
// accepted pixel goes through a software copy of the line store and window.
// That copy predicts any median beat the pixel causes. Result beats are
// compared field by field, in order, against the predicted beats.
// ----------------------------------------------------------------------------
module wmf_median_checker import wmf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  wmf_pix_if               pix,
  wmf_res_if               res,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  output int               mismatches,
  output int               pending
);

  localparam int WIN  = WINDOW_DEF;
  localparam int HALF = WIN / 2;
  localparam int AREA = WIN * WIN;

  typedef struct packed {
    logic [PIX_W-1:0]    blue;
    logic [PIX_W-1:0]    green;
    logic [PIX_W-1:0]    red;
    logic [CENTER_W-1:0] row;
    logic [CENTER_W-1:0] col;
  } median_beat_t;

  rgb_t             line_mem [WIN-1][MAX_WIDTH_DEF];
  rgb_t             win_regs [WIN][WIN];
  int               col_cnt;
  int               row_cnt;
  logic [CFG_W-1:0] width_reg;

  median_beat_t     median_q [$];
  int               fail_cnt = 0;
  int               pend_cnt = 0;

  assign mismatches = fail_cnt;
  assign pending    = pend_cnt;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    fail_cnt++;
  endtask

  task automatic check_field(input string what, input int got, input int want,
                             input median_beat_t exp_beat);
    if (got != want)
      flag_mismatch($sformatf("%s got %0d want %0d at center row %0d col %0d",
                              what, got, want, exp_beat.row, exp_beat.col));
  endtask

  // lane 0 blue, 1 green, 2 red
  function automatic logic [PIX_W-1:0] channel_median(input int lane);
    logic [PIX_W-1:0] vals [AREA];
    logic [PIX_W-1:0] cur;
    logic [3*PIX_W-1:0] word;
    int n, j, r, c;
    n = 0;
    for (r = 0; r < WIN; r++) begin
      for (c = 0; c < WIN; c++) begin
        word = win_regs[r][c];
        cur = word[lane*PIX_W +: PIX_W];
        j = n;
        while (j > 0 && vals[j-1] > cur) begin
          vals[j] = vals[j-1];
          j--;
        end
        vals[j] = cur;
        n++;
      end
    end
    return vals[AREA/2];
  endfunction

  task automatic filter_pixel(input logic sof, input rgb_t px);
    rgb_t         column [WIN];
    int           eff_w;
    int           addr;
    int           k, x;
    median_beat_t beat;
    eff_w = (width_reg == 0) ? 1 :
            (int'(width_reg) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_reg);
    if (sof) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    addr = (col_cnt >= MAX_WIDTH_DEF) ? MAX_WIDTH_DEF - 1 : col_cnt;
    // newest row sits at the bottom of the column
    column[WIN-1] = px;
    for (k = 1; k < WIN; k++) column[WIN-1-k] = line_mem[k-1][addr];
    for (k = WIN - 2; k >= 1; k--) line_mem[k][addr] = line_mem[k-1][addr];
    line_mem[0][addr] = px;
    for (k = 0; k < WIN; k++) begin
      for (x = 0; x < WIN - 1; x++) win_regs[k][x] = win_regs[k][x+1];
      win_regs[k][WIN-1] = column[k];
    end
    if (row_cnt >= WIN - 1 && col_cnt >= WIN - 1) begin
      beat.blue  = channel_median(0);
      beat.green = channel_median(1);
      beat.red   = channel_median(2);
      beat.row   = CENTER_W'(row_cnt - HALF);
      beat.col   = CENTER_W'(col_cnt - HALF);
      median_q.insert(median_q.size(), beat);
    end
    col_cnt++;
    if (col_cnt >= eff_w) begin
      col_cnt = 0;
      if (row_cnt < MAX_HEIGHT_DEF - 1) row_cnt++;
    end
  endtask

  always @(posedge clk) begin
    median_beat_t exp_beat;
    rgb_t         px;
    if (!rst_n) begin
      foreach (line_mem[i, j]) line_mem[i][j] = '0;
      foreach (win_regs[i, j]) win_regs[i][j] = '0;
      col_cnt   = 0;
      row_cnt   = 0;
      width_reg = WIDTH_RST;
      median_q.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (median_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result beat at row %0d col %0d",
                                  res.center_row, res.center_column));
        end else begin
          exp_beat = median_q.pop_front();
          check_field("blue_out", res.blue_out, exp_beat.blue, exp_beat);
          check_field("green_out", res.green_out, exp_beat.green, exp_beat);
          check_field("red_out", res.red_out, exp_beat.red, exp_beat);
          check_field("center_row", res.center_row, exp_beat.row, exp_beat);
          check_field("center_column", res.center_column, exp_beat.col, exp_beat);
        end
      end
      if (pix.valid && pix.ready) begin
        px.blue  = pix.blue_in;
        px.green = pix.green_in;
        px.red   = pix.red_in;
        filter_pixel(pix.start_of_frame, px);
      end
      // a pixel on the same edge still sees the old width
      if (cfg_wr_en) width_reg = cfg_wr_data;
    end
    pend_cnt = median_q.size();
  end

endmodule

[tb/tb_window_median_filter_rgb_unit.sv]
// ----------------------------------------------------------------------------
// tb_window_median_filter_rgb_unit
// Stimulus and verdict for the RGB median filter. A short frame runs at the
// reset width, then directed frames at the narrow widths and at a clamped
// all-ones width. One long result stall backs up the pipe. Random frames
// fill the rest of the pixel budget, a few of them cut short or missing
// their start marker. Both channels idle at random. The checker beside the
// block compares every result beat.
// ----------------------------------------------------------------------------
module tb_window_median_filter_rgb_unit;
  import wmf_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TOTAL_PIXELS   = 1950;
  localparam int SETTLE_CYCLES  = 10;
  localparam int HOLD_OFF       = 300;

  localparam logic [23:0] DIRECTED_PIX [12] = '{
    24'h000000, 24'hFFFFFF, 24'h00FF80,
    24'hFF0000, 24'h0000FF, 24'h808080,
    24'h7F7F7F, 24'h01FE00, 24'hFFFFFF,
    24'h000000, 24'h00FF00, 24'hFF00FF
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  int               mismatches;
  int               pending;

  int send_gap_max = 0;
  int recv_gap_max = 0;
  int hold_off_req = 0;
  int pixels_sent  = 0;
  int idle_cycles  = 0;

  wmf_pix_if pix_ch ();
  wmf_res_if res_ch ();

  window_median_filter_rgb_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_pix      (pix_ch),
    .out_res     (res_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  wmf_median_checker u_median_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix         (pix_ch),
    .res         (res_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // stop a hung run: no beat on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req > 0) begin
        stall = hold_off_req;
        hold_off_req = 0;
      end else begin
        stall = (recv_gap_max > 0) ? $urandom_range(recv_gap_max, 0) : 0;
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
    end
  end

  // half full range, the rest extremes and a narrow band to force ties
  function automatic logic [PIX_W-1:0] pick_level();
    case ($urandom_range(7, 0))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3:    return PIX_W'($urandom_range(135, 120));
      default: return PIX_W'($urandom_range(255, 0));
    endcase
  endfunction

  function automatic rgb_t random_pixel();
    rgb_t px;
    px.blue  = pick_level();
    px.green = pick_level();
    px.red   = pick_level();
    return px;
  endfunction

  // trim a frame to what is left of the pixel budget
  function automatic int fit_budget(input int n);
    int left;
    left = TOTAL_PIXELS - pixels_sent;
    return (n < left) ? n : left;
  endfunction

  task automatic push_pixel(input logic sof, input rgb_t px);
    int gap;
    gap = (send_gap_max > 0) ? $urandom_range(send_gap_max, 0) : 0;
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid          <= 1'b1;
    pix_ch.start_of_frame <= sof;
    pix_ch.blue_in        <= px.blue;
    pix_ch.green_in       <= px.green;
    pix_ch.red_in         <= px.red;
    do @(posedge clk); while (!(pix_ch.valid && pix_ch.ready));
    pixels_sent++;
  endtask

  task automatic send_frame(input int count, input bit with_sof);
    for (int i = 0; i < count; i++) push_pixel(with_sof && i == 0, random_pixel());
  endtask

  // drop valid, drain every expected beat, then let the pipe empty
  task automatic settle();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_width(input int w);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_W'(w);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int w;
    int rows;
    int len;
    pix_ch.valid          <= 1'b0;
    pix_ch.start_of_frame <= 1'b0;
    pix_ch.blue_in        <= '0;
    pix_ch.green_in       <= '0;
    pix_ch.red_in         <= '0;
    cfg_wr_en             <= 1'b0;
    cfg_wr_data           <= '0;
    rst_n                 <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset width: part of a first row, no window yet
    send_gap_max = 0;
    recv_gap_max = 2;
    send_frame(64, 1'b1);

    // smallest window-capable width, fixed extremes over four rows
    send_gap_max = 3;
    recv_gap_max = 3;
    set_width(3);
    for (int i = 0; i < 12; i++) push_pixel(i == 0, rgb_t'(DIRECTED_PIX[i]));

    // zero counts as one, and too narrow for any window
    set_width(0);
    send_frame(5, 1'b1);
    set_width(2);
    send_frame(8, 1'b1);

    // all-ones width clamps to the maximum
    send_gap_max = 1;
    set_width((1 << CFG_W) - 1);
    send_frame(64, 1'b1);

    // back up the pipe behind a long result stall
    send_gap_max = 0;
    recv_gap_max = 1;
    set_width(40);
    hold_off_req = HOLD_OFF;
    send_frame(40 * 6, 1'b1);

    w = 40;
    while (pixels_sent < TOTAL_PIXELS) begin
      if ($urandom_range(3, 0) == 0) begin
        send_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 11;
        recv_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 11;
        case ($urandom_range(9, 0))
          0:       w = $urandom_range(7, 3);
          1:       w = $urandom_range(200, 65);
          default: w = $urandom_range(64, 8);
        endcase
        set_width(w);
        send_frame(fit_budget(w * $urandom_range(5, 3)), 1'b1);
      end else begin
        rows = $urandom_range(6, 3);
        case ($urandom_range(9, 0))
          // carry on counting into the next image without a start marker
          0:       send_frame(fit_budget(w * rows), 1'b0);
          // frame cut short by the next start marker
          1, 2:    begin
            len = $urandom_range(3 * w, 1);
            send_frame(fit_budget(len), 1'b1);
          end
          default: send_frame(fit_budget(w * rows), 1'b1);
        endcase
      end
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
